@@ rtl/gtag_pkg.sv @@
// Shared widths, codes and types for the grey-to-glyph mapper.
package gtag_pkg;

  // Field widths fixed by the item formats.
  localparam int GI_W       = 7;
  localparam int LEVEL_W    = 8;
  localparam int PIX_W      = 8;
  localparam int CHAR_W     = 7;
  localparam int CFG_W      = 11;
  localparam int CFG_ADDR_W = 1;

  // Defaults for the top-level parameters.
  localparam int DEF_GLYPH_COUNT = 94;
  localparam int DEF_MAX_DIM     = 1024;

  // Configuration register indexes.
  localparam logic [CFG_ADDR_W-1:0] REG_ROW_WIDTH  = 1'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_FRAME_ROWS = 1'd1;

  // Operation codes of an input item.
  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_PIXEL = 1'b1;

  // Character codes.
  localparam logic [CHAR_W-1:0] CODE_NEWLINE     = 7'd10;
  localparam logic [CHAR_W-1:0] CODE_SPACE       = 7'd32;
  localparam logic [CHAR_W-1:0] CODE_FIRST_GLYPH = 7'd33;

  // Request from the sequencer to the search unit.
  typedef struct packed {
    logic             start;
    logic [PIX_W-1:0] pixel;
  } scan_req_t;

  // Status returned by the search unit.
  typedef struct packed {
    logic            done;
    logic [GI_W-1:0] index;
  } scan_stat_t;

endpackage

@@ rtl/gtag_if.sv @@
// Valid/ready channel interfaces for pixel/load items and character results.
interface gtag_req_if;
  import gtag_pkg::*;

  logic               valid;
  logic               ready;
  logic               op;
  logic [GI_W-1:0]    glyph_index;
  logic [LEVEL_W-1:0] glyph_level;
  logic [PIX_W-1:0]   pixel;

  modport source (output valid, op, glyph_index, glyph_level, pixel, input ready);
  modport sink   (input valid, op, glyph_index, glyph_level, pixel, output ready);
endinterface

interface gtag_rsp_if;
  import gtag_pkg::*;

  logic              valid;
  logic              ready;
  logic [CHAR_W-1:0] char_code;
  logic              last_of_run;
  logic              frame_done;

  modport source (output valid, char_code, last_of_run, frame_done, input ready);
  modport sink   (input valid, char_code, last_of_run, frame_done, output ready);
endinterface

@@ rtl/gtag_scan.sv @@
// Nearest-level search unit: holds the level table and scans it one entry per cycle.
module gtag_scan #(
  parameter int GLYPH_COUNT = gtag_pkg::DEF_GLYPH_COUNT
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             wr_en,
  input  logic [$clog2(GLYPH_COUNT)-1:0]   wr_addr,
  input  logic [gtag_pkg::LEVEL_W-1:0]     wr_data,
  input  gtag_pkg::scan_req_t              req,
  output gtag_pkg::scan_stat_t             stat
);
  import gtag_pkg::*;

  localparam int IDX_W = $clog2(GLYPH_COUNT);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(GLYPH_COUNT - 1);

  logic [LEVEL_W-1:0] mem [GLYPH_COUNT];
  logic [LEVEL_W-1:0] rd_data;
  logic [IDX_W-1:0]   rd_addr;
  logic               running;
  logic               cmp_valid;
  logic [IDX_W-1:0]   cmp_idx;
  logic [PIX_W-1:0]   pix;
  logic [IDX_W-1:0]   best;
  logic [PIX_W:0]     best_dist;
  logic               done;
  logic [PIX_W-1:0]   gap;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

  assign gap = (rd_data > pix) ? (rd_data - pix) : (pix - rd_data);

  always_ff @(posedge clk) begin
    if (rst) begin
      running   <= 1'b0;
      cmp_valid <= 1'b0;
      done      <= 1'b0;
    end else begin
      cmp_valid <= running;
      done      <= cmp_valid && (cmp_idx == LAST_IDX);
      if (req.start) begin
        running <= 1'b1;
      end else if (running && (rd_addr == LAST_IDX)) begin
        running <= 1'b0;
      end
    end
  end

  // Payload side of the scan: address walk, pixel hold and running minimum.
  always_ff @(posedge clk) begin
    cmp_idx <= rd_addr;
    if (req.start) begin
      rd_addr   <= '0;
      pix       <= req.pixel;
      best      <= '0;
      best_dist <= {1'b1, {PIX_W{1'b0}}};
    end else begin
      if (running && (rd_addr != LAST_IDX)) begin
        rd_addr <= rd_addr + 1'b1;
      end
      // Strict less-than keeps the lowest index on a tie.
      if (cmp_valid && ({1'b0, gap} < best_dist)) begin
        best      <= cmp_idx;
        best_dist <= {1'b0, gap};
      end
    end
  end

  assign stat.done  = done;
  assign stat.index = GI_W'(best);

endmodule

@@ rtl/grey_to_ascii_glyph_mapper_unit.sv @@
// Top level of the grey-to-glyph mapper: sequencer, raster counters and output stage.
//
//  Channel  Role    Carries
//  -------  ------  -----------------------------------------------------------
//  req      sink    op, glyph_index, glyph_level, pixel
//  rsp      source  char_code, last_of_run, frame_done
//  cfg_*    write   row_width (index 0), frame_rows (index 1)
//
// A load transaction is taken and the block is ready again at once.
// A pixel of zero has its character offered in the cycle after it is taken; any other
// pixel waits for the table scan of one entry per cycle through the single read port
// of the level memory and the shared compare.
// A newline adds one more output transaction. The block takes one item at a time and
// holds its result while rsp.ready is low. Reset is synchronous and clears the
// counters and the sequencer; the level table is not cleared and has no sweep.
module grey_to_ascii_glyph_mapper_unit #(
  parameter int GLYPH_COUNT = gtag_pkg::DEF_GLYPH_COUNT,
  parameter int MAX_DIM     = gtag_pkg::DEF_MAX_DIM
) (
  input  logic                            clk,
  input  logic                            rst,
  gtag_req_if.sink                        req,
  gtag_rsp_if.source                      rsp,
  input  logic                            cfg_wr_en,
  input  logic [gtag_pkg::CFG_ADDR_W-1:0] cfg_addr,
  input  logic [gtag_pkg::CFG_W-1:0]      cfg_wr_data
);
  import gtag_pkg::*;

  localparam int IDX_W = $clog2(GLYPH_COUNT);
  localparam int CNT_W = $clog2(MAX_DIM);
  localparam int DIM_W = $clog2(MAX_DIM + 1);
  localparam int CMP_W = (CFG_W > DIM_W) ? CFG_W : DIM_W;
  localparam logic [GI_W-1:0]  GLYPH_LIMIT = GI_W'(GLYPH_COUNT);
  localparam logic [CMP_W-1:0] DIM_LIMIT   = CMP_W'(MAX_DIM);

  // Sequencer states.
  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;
  localparam logic [1:0] ST_CHAR = 2'd2;
  localparam logic [1:0] ST_NL   = 2'd3;

  logic [1:0]        state;
  logic [1:0]        state_next;
  logic [CHAR_W-1:0] code;
  logic              last_flag;
  logic              done_flag;
  logic [CNT_W-1:0]  column_count;
  logic [CNT_W-1:0]  row_count;
  logic [DIM_W-1:0]  row_width;
  logic [DIM_W-1:0]  frame_rows;
  logic [DIM_W-1:0]  cfg_dim;
  logic [DIM_W-1:0]  col_plus;
  logic [DIM_W-1:0]  row_plus;
  logic              take;
  logic              take_pixel;
  logic              rsp_take;
  scan_req_t         scan_req;
  scan_stat_t        scan_stat;

  assign take       = req.valid && req.ready;
  assign take_pixel = take && (req.op == OP_PIXEL);
  assign rsp_take   = rsp.valid && rsp.ready;

  // Registers are held already clamped to 1..MAX_DIM.
  always_comb begin
    if (cfg_wr_data == '0) begin
      cfg_dim = DIM_W'(1);
    end else if (CMP_W'(cfg_wr_data) > DIM_LIMIT) begin
      cfg_dim = DIM_W'(MAX_DIM);
    end else begin
      cfg_dim = DIM_W'(cfg_wr_data);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row_width  <= DIM_W'(1);
      frame_rows <= DIM_W'(1);
    end else if (cfg_wr_en) begin
      case (cfg_addr)
        REG_ROW_WIDTH:  row_width  <= cfg_dim;
        REG_FRAME_ROWS: frame_rows <= cfg_dim;
        default: ;
      endcase
    end
  end

  // The search unit owns the table; loads with an index past the table are dropped.
  assign scan_req.start = take_pixel && (req.pixel != '0);
  assign scan_req.pixel = req.pixel;

  gtag_scan #(
    .GLYPH_COUNT (GLYPH_COUNT)
  ) u_scan (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (take && (req.op == OP_LOAD) && (req.glyph_index < GLYPH_LIMIT)),
    .wr_addr (req.glyph_index[IDX_W-1:0]),
    .wr_data (req.glyph_level),
    .req     (scan_req),
    .stat    (scan_stat)
  );

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (take_pixel) begin
          state_next = (req.pixel == '0) ? ST_CHAR : ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (scan_stat.done) begin
          state_next = ST_CHAR;
        end
      end
      ST_CHAR: begin
        if (rsp_take) begin
          state_next = last_flag ? ST_IDLE : ST_NL;
        end
      end
      ST_NL: begin
        if (rsp_take) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // The raster position moves on when the pixel is taken; the flags it yields are
  // kept for the character and, where a row ends mid-frame, for the newline after it.
  assign col_plus = DIM_W'(column_count) + DIM_W'(1);
  assign row_plus = DIM_W'(row_count) + DIM_W'(1);

  always_ff @(posedge clk) begin
    if (rst) begin
      column_count <= '0;
      row_count    <= '0;
    end else if (take_pixel) begin
      if (col_plus < row_width) begin
        column_count <= column_count + 1'b1;
      end else begin
        column_count <= '0;
        if (row_plus >= frame_rows) begin
          row_count <= '0;
        end else begin
          row_count <= row_count + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take_pixel) begin
      code <= CODE_SPACE;
      if (col_plus < row_width) begin
        last_flag <= 1'b1;
        done_flag <= 1'b0;
      end else if (row_plus >= frame_rows) begin
        last_flag <= 1'b1;
        done_flag <= 1'b1;
      end else begin
        last_flag <= 1'b0;
        done_flag <= 1'b0;
      end
    end else if ((state == ST_SCAN) && scan_stat.done) begin
      code <= CODE_FIRST_GLYPH + CHAR_W'(scan_stat.index);
    end
  end

  assign req.ready       = (state == ST_IDLE);
  assign rsp.valid       = (state == ST_CHAR) || (state == ST_NL);
  assign rsp.char_code   = (state == ST_NL) ? CODE_NEWLINE : code;
  assign rsp.last_of_run = (state == ST_NL) ? 1'b1 : last_flag;
  assign rsp.frame_done  = (state == ST_NL) ? 1'b0 : done_flag;

`ifndef SYNTH
  // No new item is taken while a result is still on offer.
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    req.ready |-> !rsp.valid)
    else $error("input taken while a result is pending");

  // A newline always closes the run and never marks the end of a frame.
  a_newline_flags: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && (rsp.char_code == CODE_NEWLINE)) |-> (rsp.last_of_run && !rsp.frame_done))
    else $error("newline with wrong flags");

  // The end of a frame is always the last result of its pixel.
  a_frame_last: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && rsp.frame_done) |-> rsp.last_of_run)
    else $error("frame end without end of run");

  // Once the final result of a pixel is taken, the block is ready again.
  a_ready_after_run: assert property (@(posedge clk) disable iff (rst)
    (rsp_take && rsp.last_of_run) |=> req.ready)
    else $error("not ready after end of run");

  // The search unit only finishes while the sequencer waits for it.
  a_scan_done_state: assert property (@(posedge clk) disable iff (rst)
    scan_stat.done |-> (state == ST_SCAN))
    else $error("search finished outside the scan state");
`endif

endmodule

@@ tb/glyph_char_checker.sv @@
`timescale 1ns / 1ps
// Checker that predicts the character stream of the grey-to-glyph mapper and compares it.
module glyph_char_checker
  import gtag_pkg::*;
#(
  parameter int GLYPH_COUNT = DEF_GLYPH_COUNT,
  parameter int MAX_DIM     = DEF_MAX_DIM
) (
  input  logic                  clk,
  input  logic                  rst,
  gtag_req_if                   req,
  gtag_rsp_if                   rsp,
  input  logic                  cfg_wr_en,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [CFG_W-1:0]      cfg_wr_data,
  output int                    mismatch_count,
  output int                    chars_pending
);

  localparam int CNT_W = $clog2(MAX_DIM);

  typedef struct packed {
    logic [CHAR_W-1:0] code;
    logic              last_of_run;
    logic              frame_done;
  } glyph_char_t;

  glyph_char_t        char_q[$];
  logic [LEVEL_W-1:0] level_mem [GLYPH_COUNT];
  logic [CNT_W-1:0]   col_cnt;
  logic [CNT_W-1:0]   row_cnt;
  logic [CFG_W-1:0]   row_width;
  logic [CFG_W-1:0]   frame_rows;

  function automatic logic [CFG_W-1:0] clamp_dim(input logic [CFG_W-1:0] v);
    if (v == '0) return CFG_W'(1);
    if (v > MAX_DIM) return CFG_W'(MAX_DIM);
    return v;
  endfunction

  // Index of the stored level closest to the pixel; the first one wins a tie.
  function automatic logic [GI_W-1:0] nearest_level(input logic [PIX_W-1:0] pix);
    logic [GI_W-1:0] best;
    int              best_dist;
    int              gap;
    best      = '0;
    best_dist = 256;
    for (int i = 0; i < GLYPH_COUNT; i++) begin
      gap = int'((level_mem[i] > pix) ? (level_mem[i] - pix) : (pix - level_mem[i]));
      if (gap < best_dist) begin
        best_dist = gap;
        best      = GI_W'(i);
      end
    end
    return best;
  endfunction

  // Appends one predicted character at the tail of the queue.
  function automatic void queue_char(input glyph_char_t c);
    char_q.insert(char_q.size(), c);
  endfunction

  always @(posedge clk) begin
    glyph_char_t       got;
    glyph_char_t       want;
    logic [CHAR_W-1:0] code;
    logic [CFG_W-1:0]  w;
    logic [CFG_W-1:0]  h;
    int                pushes;
    int                pops;
    int                bad;
    if (rst) begin
      char_q.delete();
      col_cnt        <= '0;
      row_cnt        <= '0;
      row_width      <= CFG_W'(1);
      frame_rows     <= CFG_W'(1);
      chars_pending  <= 0;
      mismatch_count <= 0;
    end else begin
      pushes = 0;
      pops   = 0;
      bad    = 0;
      if (cfg_wr_en) begin
        case (cfg_addr)
          REG_ROW_WIDTH:  row_width  <= cfg_wr_data;
          REG_FRAME_ROWS: frame_rows <= cfg_wr_data;
          default: ;
        endcase
      end
      if (rsp.valid && rsp.ready) begin
        pops = 1;
        got  = '{rsp.char_code, rsp.last_of_run, rsp.frame_done};
        if (char_q.size() == 0) begin
          $display("%0t: unexpected character, expected none, actual code %0d last %0b done %0b",
                   $time, got.code, got.last_of_run, got.frame_done);
          bad++;
        end else begin
          want = char_q.pop_front();
          if (got.code != want.code) begin
            $display("%0t: char_code mismatch, expected %0d, actual %0d",
                     $time, want.code, got.code);
            bad++;
          end
          if (got.last_of_run != want.last_of_run) begin
            $display("%0t: last_of_run mismatch, expected %0b, actual %0b",
                     $time, want.last_of_run, got.last_of_run);
            bad++;
          end
          if (got.frame_done != want.frame_done) begin
            $display("%0t: frame_done mismatch, expected %0b, actual %0b",
                     $time, want.frame_done, got.frame_done);
            bad++;
          end
        end
      end
      if (req.valid && req.ready) begin
        if (req.op == OP_LOAD) begin
          if (req.glyph_index < GLYPH_COUNT) level_mem[req.glyph_index] = req.glyph_level;
        end else begin
          code = (req.pixel == '0) ? CODE_SPACE : CODE_FIRST_GLYPH + nearest_level(req.pixel);
          w    = clamp_dim(row_width);
          h    = clamp_dim(frame_rows);
          if (col_cnt + 1 < w) begin
            col_cnt <= col_cnt + 1'b1;
            queue_char('{code, 1'b1, 1'b0});
            pushes = 1;
          end else begin
            col_cnt <= '0;
            if (row_cnt + 1 >= h) begin
              row_cnt <= '0;
              queue_char('{code, 1'b1, 1'b1});
              pushes = 1;
            end else begin
              row_cnt <= row_cnt + 1'b1;
              queue_char('{code, 1'b0, 1'b0});
              queue_char('{CODE_NEWLINE, 1'b1, 1'b0});
              pushes = 2;
            end
          end
        end
      end
      chars_pending  <= chars_pending + pushes - pops;
      mismatch_count <= mismatch_count + bad;
    end
  end

endmodule

@@ tb/testbench.sv @@
`timescale 1ns / 1ps
// Top of the testbench: clock, reset, stimulus and verdict for the grey-to-glyph mapper.
module testbench;
  import gtag_pkg::*;

  localparam int GLYPHS          = DEF_GLYPH_COUNT;
  // A non-zero pixel waits for the scan of the whole level table; the pause adds a margin on top of that.
  localparam int SETTLE_CYCLES   = GLYPHS + 8;
  localparam int CYCLE_LIMIT     = 1_000_000;
  localparam int HOLD_OFF_CYCLES = 600;
  localparam int NUM_PHASES      = 7;
  localparam int ITEMS_PER_PHASE = 40;

  logic                  clk = 1'b0;
  logic                  rst;
  logic                  cfg_wr_en;
  logic [CFG_ADDR_W-1:0] cfg_addr;
  logic [CFG_W-1:0]      cfg_wr_data;

  int   mismatch_count;
  int   chars_pending;
  int   cycle_count = 0;
  int   send_idle_pct;
  int   recv_idle_pct;
  logic hold_arm;
  logic hold_used = 1'b0;
  int   hold_left = 0;

  gtag_req_if pix_ch ();
  gtag_rsp_if char_ch ();

  grey_to_ascii_glyph_mapper_unit i_dut (
    .clk         (clk),
    .rst         (rst),
    .req         (pix_ch),
    .rsp         (char_ch),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_addr    (cfg_addr),
    .cfg_wr_data (cfg_wr_data)
  );

  // The checker watches both channels and the register port on its own.
  glyph_char_checker i_checker (
    .clk            (clk),
    .rst            (rst),
    .req            (pix_ch),
    .rsp            (char_ch),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_addr       (cfg_addr),
    .cfg_wr_data    (cfg_wr_data),
    .mismatch_count (mismatch_count),
    .chars_pending  (chars_pending)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Watchdog: a run that hangs, for instance on a lost character, ends here as a failure.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // Receiver. It stalls at random according to the current idling rate. Once armed, it
  // refuses every character for a long stretch, counted here, so that the block has to
  // hold its result and stop taking new items while the sender keeps offering.
  always @(posedge clk) begin
    if (rst) begin
      char_ch.ready <= 1'b0;
    end else if (hold_left != 0) begin
      char_ch.ready <= 1'b0;
      hold_left     <= hold_left - 1;
    end else if (hold_arm && !hold_used) begin
      char_ch.ready <= 1'b0;
      hold_left     <= HOLD_OFF_CYCLES;
      hold_used     <= 1'b1;
    end else begin
      char_ch.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  // Offers one transaction on the pixel channel, idling at random beforehand, and returns
  // at the clock edge at which the block accepts it.
  task automatic send_item(input logic op, input logic [GI_W-1:0] gi,
                           input logic [LEVEL_W-1:0] lvl, input logic [PIX_W-1:0] pix);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      pix_ch.valid <= 1'b0;
      @(posedge clk);
    end
    pix_ch.valid       <= 1'b1;
    pix_ch.op          <= op;
    pix_ch.glyph_index <= gi;
    pix_ch.glyph_level <= lvl;
    pix_ch.pixel       <= pix;
    do @(posedge clk); while (!pix_ch.ready);
  endtask

  // Stops offering and waits until every predicted character has arrived. A load may
  // still be in flight with nothing to show for it, so a settling pause follows.
  task automatic wait_for_quiet();
    pix_ch.valid <= 1'b0;
    do @(posedge clk); while (chars_pending != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Writes the row width and then the frame rows. Only called while the block is idle.
  task automatic set_geometry(input logic [CFG_W-1:0] width, input logic [CFG_W-1:0] rows);
    cfg_wr_en   <= 1'b1;
    cfg_addr    <= REG_ROW_WIDTH;
    cfg_wr_data <= width;
    @(posedge clk);
    cfg_addr    <= REG_FRAME_ROWS;
    cfg_wr_data <= rows;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
  endtask

  initial begin : stimulus
    int               r;
    logic [CFG_W-1:0] w;
    logic [CFG_W-1:0] h;

    // Every input that the stimulus drives is known from the very first instant.
    rst                = 1'b1;
    cfg_wr_en          = 1'b0;
    cfg_addr           = REG_ROW_WIDTH;
    cfg_wr_data        = '0;
    pix_ch.valid       = 1'b0;
    pix_ch.op          = OP_LOAD;
    pix_ch.glyph_index = '0;
    pix_ch.glyph_level = '0;
    pix_ch.pixel       = '0;
    hold_arm           = 1'b0;
    send_idle_pct      = 9;
    recv_idle_pct      = 47;

    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Three pixels per row and two rows per frame, so that the directed pixels show
    // newlines as well as frame ends.
    set_geometry(CFG_W'(3), CFG_W'(2));

    // Fill the whole level table before any non-zero pixel is converted: entry i holds
    // 40 + 2i, which gives distinct even levels and so exact ties on odd pixels between them.
    for (int i = 0; i < GLYPHS; i++) send_item(OP_LOAD, GI_W'(i), LEVEL_W'(40 + 2 * i), '0);

    // Directed part.
    send_item(OP_PIXEL, '0, '0, 8'd0);       // zero becomes a space
    send_item(OP_PIXEL, '1, '1, 8'd1);       // below every level: first glyph
    send_item(OP_PIXEL, '0, '0, 8'd41);      // tie between the first two levels
    send_item(OP_PIXEL, '0, '0, 8'd128);     // exact hit in the middle of the table
    send_item(OP_PIXEL, '0, '0, 8'd129);     // tie in the middle, lower index wins
    send_item(OP_PIXEL, '0, '0, 8'd255);     // above every level: last glyph
    // Loads with an index past the table must leave it untouched; a wrapped or
    // truncated index would move the results of the next pixels.
    send_item(OP_LOAD, 7'd127, 8'd0, '1);
    send_item(OP_PIXEL, '0, '0, 8'd1);
    send_item(OP_LOAD, 7'd94, 8'd255, '0);
    send_item(OP_PIXEL, '0, '0, 8'd255);
    // The last entry and then an early one at full darkness: the early one wins the tie.
    send_item(OP_LOAD, 7'd93, 8'd255, '0);
    send_item(OP_PIXEL, '0, '0, 8'd255);
    send_item(OP_LOAD, 7'd5, 8'd255, '0);
    send_item(OP_PIXEL, '0, '0, 8'd255);
    send_item(OP_LOAD, 7'd0, 8'd0, '0);
    send_item(OP_PIXEL, '0, '0, 8'd20);
    send_item(OP_PIXEL, '0, '0, 8'd254);
    wait_for_quiet();

    // Random part in phases. Each phase changes the geometry while the counters are
    // mid-frame, which is legal and keeps them, and covers zero and oversized values.
    // The sender idles little and the receiver much, then the reverse, then neither.
    for (int p = 0; p < NUM_PHASES; p++) begin
      if (p < 2) begin
        send_idle_pct = 9;
        recv_idle_pct = 47;
      end else if (p < 4) begin
        send_idle_pct = 47;
        recv_idle_pct = 9;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      case (p)
        0:       begin w = CFG_W'(4);    h = CFG_W'(3);    end
        1:       begin w = CFG_W'(1);    h = CFG_W'(1);    end
        2:       begin w = CFG_W'(0);    h = CFG_W'(0);    end
        3:       begin w = CFG_W'(2047); h = CFG_W'(2);    end
        4:       begin w = CFG_W'(2);    h = CFG_W'(2047); end
        5:       begin w = CFG_W'(1);    h = CFG_W'(1024); end
        default: begin w = CFG_W'(1024); h = CFG_W'(3);    end
      endcase
      set_geometry(w, h);
      if (p == 1) hold_arm <= 1'b1;

      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        // Once, the sender stops in the middle of a phase until all is delivered.
        if (p == 4 && n == ITEMS_PER_PHASE / 2) wait_for_quiet();
        r = $urandom_range(0, 99);
        if (r < 12) begin
          send_item(OP_LOAD, GI_W'($urandom_range(0, GLYPHS - 1)),
                    LEVEL_W'($urandom_range(0, 255)), PIX_W'($urandom));
        end else if (r < 16) begin
          send_item(OP_LOAD, GI_W'($urandom_range(GLYPHS, 127)),
                    LEVEL_W'($urandom_range(0, 255)), PIX_W'($urandom));
        end else if (r < 24) begin
          send_item(OP_PIXEL, GI_W'($urandom), LEVEL_W'($urandom), '0);
        end else begin
          send_item(OP_PIXEL, GI_W'($urandom), LEVEL_W'($urandom),
                    PIX_W'($urandom_range(1, 255)));
        end
      end
      wait_for_quiet();
    end

    if (mismatch_count == 0 && chars_pending == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
